>>> sv/ffsa_pkg.sv
// Types and constants shared by the first-fit segment allocator.
// No dependencies; used by ffsa_cell and first_fit_segment_allocator_top.
package ffsa_pkg;

	localparam int AW = 32;
	localparam int PAGE_BYTES = 4096;
	localparam int HEADER_BYTES = 32;
	localparam int ALIGN_BYTES = 16;
	localparam int PAGE_BITS = $clog2(PAGE_BYTES);

	localparam logic [AW-1:0] PAGE_W = AW'(PAGE_BYTES);
	localparam logic [AW-1:0] HEADER_W = AW'(HEADER_BYTES);
	localparam logic [AW-1:0] ALIGN_W = AW'(ALIGN_BYTES);
	localparam logic [AW-1:0] SPLIT_MIN_W = AW'(HEADER_BYTES + ALIGN_BYTES);

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_ADD   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_e;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_PICK,
		FSM_MERGE,
		FSM_PAGE,
		FSM_SHIFT,
		FSM_WRITE
	} fsm_e;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_FROM_LEFT,
		OP_FROM_RIGHT,
		OP_LOAD
	} cell_op_e;

	typedef struct packed {
		logic [AW-1:0] start;
		logic [AW-1:0] size;
	} seg_t;

	typedef struct packed {
		cell_op_e op;
		seg_t     seg;
	} cell_ctrl_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [23:0] request_bytes;
		logic [31:0] payload_address;
		logic [31:0] block_bytes;
		logic [31:0] region_start;
		logic [31:0] region_bytes;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] granted_address;
		logic [31:0] granted_bytes;
		logic [31:0] page_request_bytes;
		logic        pages_released;
		logic [31:0] release_start;
		logic [31:0] release_bytes;
	} out_t;

endpackage

>>> sv/first_fit_segment_allocator_top.sv
// First-fit free-segment allocator with coalescing, built as a chain of segment cells.
// States per item: SCAN, PICK, MERGE, PAGE, SHIFT while the table moves, then WRITE.
// New items wait until the last result is written; the chain moves one slot per cycle.
// Reset: arst_n clears the cell occupancy bits (table empty) and the control state.
// Depends on ffsa_pkg and ffsa_cell.
module first_fit_segment_allocator_top #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ffsa_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ffsa_pkg::out_t  out_data
);

	localparam int N = MAX_SEGMENTS;
	localparam int AW = ffsa_pkg::AW;
	localparam int PB = ffsa_pkg::PAGE_BITS;

	ffsa_pkg::fsm_e state_q, state_d;

	ffsa_pkg::in_t  req_q;
	ffsa_pkg::out_t out_q;
	logic           out_valid_q;

	// cell wiring
	ffsa_pkg::cell_ctrl_t ctrl_w [N];
	ffsa_pkg::seg_t       seg_w  [N];
	logic [N-1:0]         occ_w;
	logic [N-1:0]         hit_w;

	// search results
	logic [N-1:0]   hit_q;
	logic [N-1:0]   p_oh_q, prev_oh_q;
	logic           has_prev_q, has_cur_q;
	ffsa_pkg::seg_t cur_q, prev_q;

	// merge results
	logic           merge_lo_q, merge_hi_q;
	logic [AW-1:0]  ms_q, mz_q;

	// splice plan
	ffsa_pkg::out_t res_q;
	logic [N-1:0]   lo_oh_q;
	logic [1:0]     shift_cnt_q;
	logic           shift_left_q;
	logic [1:0]     k_q;
	ffsa_pkg::seg_t e0_q, e1_q;

	// request derived values
	logic [AW-1:0] need;
	logic [AW-1:0] free_start;
	logic [AW-1:0] key;
	logic          key_on_size;

	assign need = ((AW'(req_q.request_bytes) + ffsa_pkg::ALIGN_W - AW'(1))
		& ~(ffsa_pkg::ALIGN_W - AW'(1))) + ffsa_pkg::HEADER_W;
	assign free_start = req_q.payload_address - ffsa_pkg::HEADER_W;
	assign key_on_size = (req_q.command == ffsa_pkg::CMD_ALLOC);
	assign key = (req_q.command == ffsa_pkg::CMD_ALLOC) ? need :
		(req_q.command == ffsa_pkg::CMD_FREE) ? free_start : req_q.region_start;

	// ------------------------------------------------------------------
	// cell chain
	// ------------------------------------------------------------------
	for (genvar j = 0; j < N; j++) begin : g_cell
		ffsa_pkg::seg_t l_seg, r_seg;
		logic           l_occ, r_occ;
		if (j == 0) begin : g_first
			assign l_seg = '0;
			assign l_occ = 1'b0;
		end else begin : g_mid_l
			assign l_seg = seg_w[j-1];
			assign l_occ = occ_w[j-1];
		end
		if (j == N-1) begin : g_last
			assign r_seg = '0;
			assign r_occ = 1'b0;
		end else begin : g_mid_r
			assign r_seg = seg_w[j+1];
			assign r_occ = occ_w[j+1];
		end
		ffsa_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl_w[j]),
			.left_seg   (l_seg),
			.left_occ   (l_occ),
			.right_seg  (r_seg),
			.right_occ  (r_occ),
			.key_on_size(key_on_size),
			.key        (key),
			.seg        (seg_w[j]),
			.occ        (occ_w[j]),
			.hit        (hit_w[j])
		);
	end

	// ------------------------------------------------------------------
	// position pick: first hit, or first empty slot (insert position)
	// ------------------------------------------------------------------
	logic [N-1:0]   pick_t, p_oh, prev_oh;
	ffsa_pkg::seg_t cur_mux, prev_mux;

	assign pick_t = hit_q | ~occ_w;
	assign p_oh = pick_t & (~pick_t + N'(1));
	assign prev_oh = (p_oh == '0) ? {1'b1, {(N-1){1'b0}}} : (p_oh >> 1);

	always_comb begin
		cur_mux = '0;
		prev_mux = '0;
		for (int j = 0; j < N; j++) begin
			cur_mux = ffsa_pkg::seg_t'(cur_mux | ({2*AW{p_oh[j]}} & seg_w[j]));
			prev_mux = ffsa_pkg::seg_t'(prev_mux | ({2*AW{prev_oh[j]}} & seg_w[j]));
		end
	end

	// ------------------------------------------------------------------
	// merge test: both neighbors checked against the freed block
	// ------------------------------------------------------------------
	logic          m_lo, m_hi;
	logic [AW-1:0] m_s, m_z;

	always_comb begin
		m_lo = has_prev_q && ((prev_q.start + prev_q.size) == free_start);
		m_hi = has_cur_q && ((free_start + req_q.block_bytes) == cur_q.start);
		m_s = m_lo ? prev_q.start : free_start;
		m_z = req_q.block_bytes + (m_lo ? prev_q.size : '0) + (m_hi ? cur_q.size : '0);
	end

	// ------------------------------------------------------------------
	// page math and splice plan
	// ------------------------------------------------------------------
	logic [AW:0]    p_end, p_fb, p_lb;
	logic           p_rel;
	ffsa_pkg::out_t plan_res;
	logic [N-1:0]   plan_lo;
	logic [1:0]     plan_cnt, plan_k, plan_del;
	logic           plan_left;
	ffsa_pkg::seg_t plan_e0, plan_e1;
	logic [AW-1:0]  a_left;
	logic signed [2:0] plan_d;

	always_comb begin
		p_end = {1'b0, ms_q} + {1'b0, mz_q};
		p_fb = (ms_q[PB-1:0] != '0) ?
			{({1'b0, ms_q[AW-1:PB]} + (AW-PB+1)'(1)), {PB{1'b0}}} : {1'b0, ms_q};
		p_lb = {p_end[AW:PB], {PB{1'b0}}};
		p_rel = !p_end[AW] && !p_fb[AW] && (p_fb < p_lb);
		a_left = cur_q.size - need;

		plan_res = '0;
		plan_lo = p_oh_q;
		plan_cnt = 2'd0;
		plan_left = 1'b0;
		plan_k = 2'd0;
		plan_e0 = '0;
		plan_e1 = '0;
		plan_del = 2'd0;
		plan_d = '0;

		case (ffsa_pkg::cmd_e'(req_q.command))
			ffsa_pkg::CMD_ALLOC: begin
				if (!has_cur_q) begin
					plan_res.status = ffsa_pkg::ST_NOFIT;
					plan_res.page_request_bytes = (need + ffsa_pkg::PAGE_W - AW'(1))
						& ~(ffsa_pkg::PAGE_W - AW'(1));
				end else begin
					plan_res.granted_address = cur_q.start + ffsa_pkg::HEADER_W;
					if (a_left >= ffsa_pkg::SPLIT_MIN_W) begin
						plan_res.granted_bytes = need;
						plan_k = 2'd1;
						plan_e0.start = cur_q.start + need;
						plan_e0.size = a_left;
					end else begin
						plan_res.granted_bytes = cur_q.size;
						plan_cnt = 2'd1;
						plan_left = 1'b1;
					end
				end
			end
			ffsa_pkg::CMD_FREE: begin
				plan_del = {1'b0, merge_lo_q} + {1'b0, merge_hi_q};
				plan_lo = merge_lo_q ? prev_oh_q : p_oh_q;
				if (p_rel) begin
					plan_k = {1'b0, (p_fb[AW-1:0] != ms_q)} + {1'b0, (p_lb != p_end)};
					plan_e1.start = p_lb[AW-1:0];
					plan_e1.size = p_end[AW-1:0] - p_lb[AW-1:0];
					if (p_fb[AW-1:0] != ms_q) begin
						plan_e0.start = ms_q;
						plan_e0.size = p_fb[AW-1:0] - ms_q;
					end else begin
						plan_e0 = plan_e1;
					end
				end else begin
					plan_k = 2'd1;
					plan_e0.start = ms_q;
					plan_e0.size = mz_q;
				end
				plan_d = signed'({1'b0, plan_k}) - signed'({1'b0, plan_del});
				if ((plan_d == 3'sd1 && occ_w[N-1]) || (plan_d == 3'sd2 && occ_w[N-2])) begin
					plan_res.status = ffsa_pkg::ST_FULL;
					plan_k = 2'd0;
				end else begin
					plan_left = plan_d[2];
					plan_cnt = plan_d[2] ? 2'(-plan_d) : plan_d[1:0];
					if (p_rel) begin
						plan_res.pages_released = 1'b1;
						plan_res.release_start = p_fb[AW-1:0];
						plan_res.release_bytes = p_lb[AW-1:0] - p_fb[AW-1:0];
					end
				end
			end
			ffsa_pkg::CMD_ADD: begin
				if (occ_w[N-1]) begin
					plan_res.status = ffsa_pkg::ST_FULL;
				end else begin
					plan_cnt = 2'd1;
					plan_k = 2'd1;
					plan_e0.start = req_q.region_start;
					plan_e0.size = req_q.region_bytes;
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// cell control: shift around lo, then load new entries
	// ------------------------------------------------------------------
	logic [N-1:0] ge_lo, gt_lo;
	logic         commit;

	assign ge_lo = lo_oh_q | (~lo_oh_q + N'(1));
	assign gt_lo = ge_lo & ~lo_oh_q;
	assign commit = (state_q == ffsa_pkg::FSM_WRITE) && (!out_valid_q || out_ready);

	always_comb begin
		for (int j = 0; j < N; j++) begin
			ctrl_w[j].op = ffsa_pkg::OP_HOLD;
			ctrl_w[j].seg = lo_oh_q[j] ? e0_q : e1_q;
			if (state_q == ffsa_pkg::FSM_SHIFT) begin
				if (shift_left_q ? ge_lo[j] : gt_lo[j]) begin
					ctrl_w[j].op = shift_left_q ? ffsa_pkg::OP_FROM_RIGHT
						: ffsa_pkg::OP_FROM_LEFT;
				end
			end else if (commit) begin
				if (lo_oh_q[j] && k_q != 2'd0) begin
					ctrl_w[j].op = ffsa_pkg::OP_LOAD;
				end else if (j > 0 && k_q == 2'd2) begin
					if (lo_oh_q[(j > 0) ? j-1 : 0]) begin
						ctrl_w[j].op = ffsa_pkg::OP_LOAD;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffsa_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		case (state_q)
			ffsa_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ffsa_pkg::FSM_SCAN;
			end
			ffsa_pkg::FSM_SCAN:  state_d = ffsa_pkg::FSM_PICK;
			ffsa_pkg::FSM_PICK:  state_d = ffsa_pkg::FSM_MERGE;
			ffsa_pkg::FSM_MERGE: state_d = ffsa_pkg::FSM_PAGE;
			ffsa_pkg::FSM_PAGE: begin
				state_d = (plan_cnt == 2'd0) ? ffsa_pkg::FSM_WRITE : ffsa_pkg::FSM_SHIFT;
			end
			ffsa_pkg::FSM_SHIFT: begin
				if (shift_cnt_q == 2'd1) state_d = ffsa_pkg::FSM_WRITE;
			end
			ffsa_pkg::FSM_WRITE: begin
				if (!out_valid_q || out_ready) state_d = ffsa_pkg::FSM_IDLE;
			end
			default: state_d = ffsa_pkg::FSM_IDLE;
		endcase
	end

	// hold the accepted item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) req_q <= in_data;
	end

	// capture hits, pick, merge and plan as the sequencer advances
	always_ff @(posedge clk) begin
		if (state_q == ffsa_pkg::FSM_SCAN) hit_q <= hit_w;
		if (state_q == ffsa_pkg::FSM_PICK) begin
			p_oh_q <= p_oh;
			prev_oh_q <= prev_oh;
			has_prev_q <= !p_oh[0];
			has_cur_q <= |(p_oh & occ_w);
			cur_q <= cur_mux;
			prev_q <= prev_mux;
		end
		if (state_q == ffsa_pkg::FSM_MERGE) begin
			merge_lo_q <= m_lo;
			merge_hi_q <= m_hi;
			ms_q <= m_s;
			mz_q <= m_z;
		end
		if (state_q == ffsa_pkg::FSM_PAGE) begin
			res_q <= plan_res;
			lo_oh_q <= plan_lo;
			shift_left_q <= plan_left;
			k_q <= plan_k;
			e0_q <= plan_e0;
			e1_q <= plan_e1;
		end
		if (commit) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_cnt_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ffsa_pkg::FSM_PAGE) begin
				shift_cnt_q <= plan_cnt;
			end else if (state_q == ffsa_pkg::FSM_SHIFT) begin
				shift_cnt_q <= shift_cnt_q - 2'd1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_occ_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_w & ~{occ_w[N-2:0], 1'b1}) == '0)
		else $error("segment table has a hole");

	a_shift_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffsa_pkg::FSM_SHIFT |-> shift_cnt_q != 2'd0)
		else $error("shift step with zero count");

	a_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffsa_pkg::FSM_MERGE |-> $onehot0(p_oh_q))
		else $error("pick position not one-hot");

	a_full_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		commit && res_q.status == ffsa_pkg::ST_FULL |-> k_q == 2'd0)
		else $error("table-full item loads segments");

endmodule

>>> sv/ffsa_cell.sv
// One slot of the segment chain: holds a free segment and its occupancy bit.
// Depends on ffsa_pkg.
module ffsa_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ffsa_pkg::cell_ctrl_t ctrl,
	input  ffsa_pkg::seg_t    left_seg,
	input  logic              left_occ,
	input  ffsa_pkg::seg_t    right_seg,
	input  logic              right_occ,
	input  logic              key_on_size,
	input  logic [ffsa_pkg::AW-1:0] key,
	output ffsa_pkg::seg_t    seg,
	output logic              occ,
	output logic              hit
);

	ffsa_pkg::seg_t seg_q;
	logic           occ_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			ffsa_pkg::OP_FROM_LEFT:  seg_q <= left_seg;
			ffsa_pkg::OP_FROM_RIGHT: seg_q <= right_seg;
			ffsa_pkg::OP_LOAD:       seg_q <= ctrl.seg;
			default:                 seg_q <= seg_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			case (ctrl.op)
				ffsa_pkg::OP_FROM_LEFT:  occ_q <= left_occ;
				ffsa_pkg::OP_FROM_RIGHT: occ_q <= right_occ;
				ffsa_pkg::OP_LOAD:       occ_q <= 1'b1;
				default:                 occ_q <= occ_q;
			endcase
		end
	end

	// fit test for allocate, address order test otherwise
	assign hit = occ_q && (key_on_size ? (seg_q.size >= key) : (seg_q.start >= key));
	assign seg = seg_q;
	assign occ = occ_q;

endmodule

>>> dv/tb_first_fit_segment_allocator_top.sv
// Testbench for first_fit_segment_allocator_top: directed items, table fill and
// drain, random allocate/free/add traffic, all checked by a first-fit predictor.
// Depends on ffsa_pkg and the RTL of first_fit_segment_allocator_top.
module tb_first_fit_segment_allocator_top;

	localparam int NSEG = 64;
	localparam int PG = 4096;
	localparam int HDR = 32;
	localparam int ALN = 16;
	localparam int STALL_MAX = 13;
	localparam int RANDOM_ITEMS = 1700;
	localparam int WATCHDOG_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	ffsa_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	ffsa_pkg::out_t out_data;

	// Directed row: the expected result is used only when has_fixed is set.
	typedef struct {
		ffsa_pkg::in_t  item;
		bit             has_fixed;
		ffsa_pkg::out_t fixed;
	} row_t;

	// Predictor copy of the free-segment table.
	logic [31:0] free_start[NSEG];
	logic [31:0] free_size[NSEG];
	int free_count;

	ffsa_pkg::out_t pending_results[$];
	row_t directed_rows[$];
	int mismatches;
	int idle_cycles = 0;

	// Live blocks handed out by the block, used to build sensible frees.
	logic [31:0] live_addr[$];
	logic [31:0] live_size[$];

	first_fit_segment_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Replace entries [pos, pos+del) with k new entries.
	function automatic void table_splice(int pos, int del, int k,
			logic [31:0] s0, logic [31:0] z0, logic [31:0] s1, logic [31:0] z1);
		logic [31:0] ts[NSEG];
		logic [31:0] tz[NSEG];
		int n;
		n = 0;
		for (int i = 0; i < pos; i++) begin
			ts[n] = free_start[i]; tz[n] = free_size[i]; n++;
		end
		if (k > 0) begin
			ts[n] = s0; tz[n] = z0; n++;
		end
		if (k > 1) begin
			ts[n] = s1; tz[n] = z1; n++;
		end
		for (int i = pos + del; i < free_count; i++) begin
			ts[n] = free_start[i]; tz[n] = free_size[i]; n++;
		end
		for (int i = 0; i < n; i++) begin
			free_start[i] = ts[i]; free_size[i] = tz[i];
		end
		free_count = n;
	endfunction

	function automatic int first_at_or_above(logic [31:0] a);
		int i;
		for (i = 0; i < free_count; i++)
			if (free_start[i] >= a)
				break;
		return i;
	endfunction

	// Work out the result of one item and update the table copy.
	function automatic ffsa_pkg::out_t allocate_free_predict(ffsa_pkg::in_t it);
		ffsa_pkg::out_t r;
		logic [32:0] need, left;
		logic [31:0] s, z;
		logic [32:0] fe, fb, lb, endw;
		int i, p, lo, del, k;
		bit rel;
		logic [31:0] s0, z0, s1, z1;
		r = '0;
		case (ffsa_pkg::cmd_e'(it.command))
			ffsa_pkg::CMD_ALLOC: begin
				need = ((33'(it.request_bytes) + ALN - 1) / ALN) * ALN + HDR;
				for (i = 0; i < free_count; i++)
					if (33'(free_size[i]) >= need)
						break;
				if (i == free_count) begin
					r.status = ffsa_pkg::ST_NOFIT;
					r.page_request_bytes = 32'(((need + PG - 1) / PG) * PG);
				end else begin
					s = free_start[i];
					left = 33'(free_size[i]) - need;
					r.granted_address = s + HDR;
					if (left >= 33'(HDR + ALN)) begin
						free_start[i] = s + 32'(need);
						free_size[i] = 32'(left);
						r.granted_bytes = 32'(need);
					end else begin
						r.granted_bytes = free_size[i];
						table_splice(i, 1, 0, 0, 0, 0, 0);
					end
				end
			end
			ffsa_pkg::CMD_FREE: begin
				s = it.payload_address - HDR;
				z = it.block_bytes;
				p = first_at_or_above(s);
				lo = p;
				del = 0;
				if (p > 0 && free_start[p-1] + free_size[p-1] == s) begin
					lo = p - 1; del = 1;
					s = free_start[p-1];
					z = free_size[p-1] + z;
				end
				if (p < free_count && s + z == free_start[p]) begin
					z = z + free_size[p];
					del++;
				end
				endw = 33'(s) + 33'(z);
				fb = (s % PG) != 0 ? 33'(s) + (PG - (s % PG)) : 33'(s);
				rel = 1'b0;
				lb = 0;
				if (!endw[32] && !fb[32]) begin
					lb = endw - (endw % PG);
					rel = fb < lb;
				end
				k = 0;
				s0 = s; z0 = z; s1 = 0; z1 = 0;
				if (rel) begin
					if (fb > 33'(s)) begin
						s0 = s; z0 = 32'(fb) - s; k++;
					end
					if (lb < endw) begin
						if (k == 0) begin
							s0 = 32'(lb); z0 = 32'(endw - lb);
						end else begin
							s1 = 32'(lb); z1 = 32'(endw - lb);
						end
						k++;
					end
				end else begin
					k = 1;
				end
				if (free_count - del + k > NSEG) begin
					r.status = ffsa_pkg::ST_FULL;
				end else begin
					table_splice(lo, del, k, s0, z0, s1, z1);
					if (rel) begin
						r.pages_released = 1'b1;
						r.release_start = 32'(fb);
						r.release_bytes = 32'(lb - fb);
					end
				end
			end
			ffsa_pkg::CMD_ADD: begin
				if (free_count >= NSEG)
					r.status = ffsa_pkg::ST_FULL;
				else
					table_splice(first_at_or_above(it.region_start), 0, 1,
						it.region_start, it.region_bytes, 0, 0);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatches++;
	endtask

	// Drive one item; hold valid with a steady payload until accepted.
	// Valid stays high after the accept; drop it before any pause.
	task automatic send_item(ffsa_pkg::in_t it);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(allocate_free_predict(it));
	endtask

	function automatic ffsa_pkg::in_t make_item(ffsa_pkg::cmd_e c, logic [23:0] rq,
			logic [31:0] pa, logic [31:0] bb, logic [31:0] rs, logic [31:0] rb);
		ffsa_pkg::in_t it;
		it.command = c;
		it.request_bytes = rq;
		it.payload_address = pa;
		it.block_bytes = bb;
		it.region_start = rs;
		it.region_bytes = rb;
		return it;
	endfunction

	function automatic void add_row(ffsa_pkg::in_t it, bit fx, ffsa_pkg::out_t f);
		row_t r;
		r.item = it; r.has_fixed = fx; r.fixed = f;
		directed_rows.push_back(r);
	endfunction

	// Random item: mostly well-formed allocate/free/add traffic, some noise.
	function automatic ffsa_pkg::in_t random_item();
		ffsa_pkg::in_t it;
		int sel, j;
		it.command = 2'($urandom);
		it.request_bytes = 24'($urandom);
		it.payload_address = $urandom;
		it.block_bytes = $urandom;
		it.region_start = $urandom;
		it.region_bytes = $urandom;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			it.command = ffsa_pkg::CMD_ALLOC;
			if ($urandom_range(0, 9) != 0)
				it.request_bytes = 24'($urandom_range(0, 6000));
		end else if (sel < 70 && live_addr.size() > 0) begin
			j = $urandom_range(0, live_addr.size() - 1);
			it.command = ffsa_pkg::CMD_FREE;
			it.payload_address = live_addr[j];
			it.block_bytes = live_size[j];
			live_addr.delete(j);
			live_size.delete(j);
		end else if (sel < 90) begin
			it.command = ffsa_pkg::CMD_ADD;
			if ($urandom_range(0, 4) != 0) begin
				it.region_start = $urandom & 32'hFFFF_F000;
				it.region_bytes = 32'($urandom_range(1, 4)) * PG;
			end
		end else if (sel < 95) begin
			it.command = ffsa_pkg::CMD_FREE;
		end else begin
			it.command = ffsa_pkg::CMD_NONE;
		end
		return it;
	endfunction

	// Result side: random stalls, compare each result with the oldest expectation.
	initial begin
		ffsa_pkg::out_t want;
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, STALL_MAX);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'(out_data.status), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.status != want.status)
					report_mismatch("status", 32'(out_data.status), 32'(want.status));
				if (out_data.granted_address != want.granted_address)
					report_mismatch("granted_address", out_data.granted_address,
						want.granted_address);
				if (out_data.granted_bytes != want.granted_bytes)
					report_mismatch("granted_bytes", out_data.granted_bytes,
						want.granted_bytes);
				if (out_data.page_request_bytes != want.page_request_bytes)
					report_mismatch("page_request_bytes", out_data.page_request_bytes,
						want.page_request_bytes);
				if (out_data.pages_released != want.pages_released)
					report_mismatch("pages_released", 32'(out_data.pages_released),
						32'(want.pages_released));
				if (out_data.release_start != want.release_start)
					report_mismatch("release_start", out_data.release_start,
						want.release_start);
				if (out_data.release_bytes != want.release_bytes)
					report_mismatch("release_bytes", out_data.release_bytes,
						want.release_bytes);
				// Track granted blocks so later frees hand them back.
				if (want.status == ffsa_pkg::ST_DONE && want.granted_bytes != 0) begin
					live_addr.push_back(want.granted_address);
					live_size.push_back(want.granted_bytes);
				end
			end
		end
	end

	// Watchdog: end the run when nothing is accepted for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		ffsa_pkg::out_t f;
		ffsa_pkg::in_t it;
		mismatches = 0;
		free_count = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: every allocate misses and asks for pages.
		f = '0; f.status = ffsa_pkg::ST_NOFIT; f.page_request_bytes = 32'(PG);
		add_row(make_item(ffsa_pkg::CMD_ALLOC, 24'd0, 0, 0, 0, 0), 1, f);
		f.page_request_bytes = 32'h0100_1000;
		add_row(make_item(ffsa_pkg::CMD_ALLOC, 24'hFF_FFFF, 0, 0, 0, 0), 1, f);
		f = '0; f.status = ffsa_pkg::ST_NOFIT; f.page_request_bytes = 32'(2 * PG);
		add_row(make_item(ffsa_pkg::CMD_ALLOC, 24'(PG), 0, 0, 0, 0), 1, f);
		// Unknown command does nothing.
		add_row(make_item(ffsa_pkg::CMD_NONE, 24'hFF_FFFF, '1, '1, '1, '1), 1, '0);
		// Host answers a miss with a page, then retries; splits and a request that misses.
		add_row(make_item(ffsa_pkg::CMD_ADD, 0, 0, 0, 32'h0001_0000, 32'(PG)), 1, '0);
		add_row(make_item(ffsa_pkg::CMD_ALLOC, 24'd1, 0, 0, 0, 0), 0, '0);
		add_row(make_item(ffsa_pkg::CMD_ALLOC, 24'd100, 0, 0, 0, 0), 0, '0);
		add_row(make_item(ffsa_pkg::CMD_ALLOC, 24'd3900, 0, 0, 0, 0), 0, '0);
		add_row(make_item(ffsa_pkg::CMD_ALLOC, 24'd1, 0, 0, 0, 0), 0, '0);
		// Frees that merge with neighbors and release whole pages.
		add_row(make_item(ffsa_pkg::CMD_FREE, 0, 32'h0001_0020, 32'd48, 0, 0), 0, '0);
		add_row(make_item(ffsa_pkg::CMD_FREE, 0, 32'h0001_0050, 32'd144, 0, 0), 0, '0);
		add_row(make_item(ffsa_pkg::CMD_FREE, 0, 32'h0001_00E0, 32'd3936, 0, 0), 0, '0);
		// Zero sizes, top of the address space, wrap past the top.
		add_row(make_item(ffsa_pkg::CMD_ADD, 0, 0, 0, 32'hFFFF_FFF0, 32'd0), 1, '0);
		add_row(make_item(ffsa_pkg::CMD_FREE, 0, 32'd0, 32'd0, 0, 0), 0, '0);
		add_row(make_item(ffsa_pkg::CMD_FREE, 0, 32'h0000_0010, 32'h0000_3000, 0, 0), 0, '0);
		add_row(make_item(ffsa_pkg::CMD_ADD, 0, 0, 0, 32'hFFFF_F000, '1), 1, '0);
		add_row(make_item(ffsa_pkg::CMD_FREE, 0, '1, '1, 0, 0), 0, '0);
		add_row(make_item(ffsa_pkg::CMD_ALLOC, 24'hFF_FFFF, 0, 0, 0, 0), 0, '0);

		foreach (directed_rows[n]) begin
			send_item(directed_rows[n].item);
			// A typed-in expectation must agree with the predictor.
			if (directed_rows[n].has_fixed && pending_results[$] != directed_rows[n].fixed)
				report_mismatch("directed row", 32'(n), 32'd0);
		end

		// Fill the table with adds until it reports full.
		for (int n = 0; n < NSEG + 2; n++)
			send_item(make_item(ffsa_pkg::CMD_ADD, 0, 0, 0, 32'(n) * 32'h0002_0000, 32'd64));
		send_item(make_item(ffsa_pkg::CMD_FREE, 0, 32'h0001_0020, 32'd16, 0, 0));
		send_item(make_item(ffsa_pkg::CMD_FREE, 0, 32'h0000_0060, 32'd64, 0, 0));

		// Hold off until every expected result has come.
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);

		// Drain the full table with allocates so random traffic has room.
		for (int n = 0; n < NSEG; n++)
			send_item(make_item(ffsa_pkg::CMD_ALLOC, 24'd16, 0, 0, 0, 0));
		live_addr.delete();
		live_size.delete();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			it = random_item();
			send_item(it);
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
sv/ffsa_pkg.sv
sv/ffsa_cell.sv
sv/first_fit_segment_allocator_top.sv
dv/tb_first_fit_segment_allocator_top.sv
